// ----- design/rrcp_pkg.sv -----
// ----------------------------------------------------------------------------
// rrcp_pkg
// Shared types and constants of the rectangle copy/cut/paste engine.
// ----------------------------------------------------------------------------
`default_nettype none

package rrcp_pkg;

    localparam int ADDR_W  = 12;
    localparam int PIXELS  = 4096;
    localparam int PIX_W   = 32;
    localparam int SIDE_W  = 7;
    localparam int COL_W   = 6;
    localparam int CNT_W   = 13;
    localparam int DIV_CNT_W = 4;
    localparam logic [SIDE_W-1:0] MAX_SIDE   = 7'd64;
    localparam logic [SIDE_W-1:0] WIDTH_RST  = 7'd16;
    localparam logic [SIDE_W-1:0] HEIGHT_RST = 7'd16;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef enum logic [2:0] {
        OP_WRITE = 3'd0,
        OP_READ  = 3'd1,
        OP_COPY  = 3'd2,
        OP_CUT   = 3'd3,
        OP_PASTE = 3'd4
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_RDATA,
        S_DIV_A,
        S_DIV_B,
        S_SETUP,
        S_READ,
        S_WRITE,
        S_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic set_err;
        logic pix_wr_single;
        logic pix_rd_single;
        logic cap_rd;
        logic div_start;
        logic div_sel_b;
        logic cap_a;
        logic cap_b;
        logic setup;
        logic walk_read;
        logic walk_write;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        op_t  op;
        logic a_bad;
        logic b_bad;
        logic div_done;
        logic walk_last;
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- design/rrcp_div.sv -----
// ----------------------------------------------------------------------------
// rrcp_div
// Restoring divider, one quotient bit per cycle: index by row width.
// ----------------------------------------------------------------------------
`default_nettype none

module rrcp_div
    import rrcp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [ADDR_W-1:0] dividend,
    input  wire logic [SIDE_W-1:0] divisor,
    output logic                   done,
    output logic [ADDR_W-1:0]      quotient,
    output logic [COL_W-1:0]       remainder
);

    logic [SIDE_W:0]      rem_reg;
    logic [ADDR_W-1:0]    quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [SIDE_W:0]      trial;
    logic                 fits;

    assign trial = {rem_reg[SIDE_W-1:0], quo_reg[ADDR_W-1]};
    assign fits  = trial >= {1'b0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DIV_CNT_W'(ADDR_W);
        end
        else if (busy_reg)
        begin
            cnt_reg  <= cnt_reg - 1'b1;
            busy_reg <= cnt_reg != DIV_CNT_W'(1);
            done_reg <= cnt_reg == DIV_CNT_W'(1);
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial - {1'b0, divisor} : trial;
            quo_reg <= {quo_reg[ADDR_W-2:0], fits};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[COL_W-1:0];

endmodule

`default_nettype wire

// ----- design/rrcp_dpath.sv -----
// ----------------------------------------------------------------------------
// rrcp_dpath
// Datapath: size registers, pixel and clipboard stores, rectangle walker.
// ----------------------------------------------------------------------------
`default_nettype none

module rrcp_dpath
    import rrcp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic              cfg_index,
    input  wire logic [SIDE_W-1:0] cfg_data,
    input  wire logic [63:0]       in_data,
    input  wire ctrl_cmd_t         cmd,
    output dp_stat_t               stat,
    output logic [47:0]            out_data
);

    logic [SIDE_W-1:0] width_reg, height_reg;
    logic [SIDE_W-1:0] w, h;
    logic [13:0]       limit;

    op_t               op_reg;
    logic [ADDR_W-1:0] a_reg, b_reg;
    logic [PIX_W-1:0]  val_reg;

    logic [ADDR_W-1:0] clip_start_reg, clip_end_reg;
    logic [COL_W-1:0]  clip_span_reg;

    logic [ADDR_W-1:0] qa_reg, qb_reg;
    logic [COL_W-1:0]  ra_reg, rb_reg;

    logic [SIDE_W-1:0] nrows_reg, ncols_reg, row_reg, col_reg;
    logic [SIDE_W-1:0] src_stride_reg, dst_stride_reg;
    logic [ADDR_W-1:0] src_reg, src_row_reg, dst_reg, dst_row_reg;

    logic [PIX_W-1:0]  rd_reg;
    logic              err_reg;
    logic [CNT_W-1:0]  moved_reg;
    logic [PIX_W-1:0]  out_rd_reg;
    logic              out_st_reg;
    logic [CNT_W-1:0]  out_cnt_reg;

    logic [PIX_W-1:0]  pix_mem [0:PIXELS-1];
    logic [PIX_W-1:0]  clip_mem [0:PIXELS-1];
    logic [PIX_W-1:0]  pix_rd_reg, clip_rd_reg;

    logic              div_done;
    logic [ADDR_W-1:0] div_quo, div_dividend;
    logic [COL_W-1:0]  div_rem;
    logic [ADDR_W-1:0] diff;

    // side limits saturate to 1..MAX_SIDE
    assign w = (width_reg == '0) ? SIDE_W'(1) : (width_reg > MAX_SIDE) ? MAX_SIDE : width_reg;
    assign h = (height_reg == '0) ? SIDE_W'(1)
             : (height_reg > MAX_SIDE) ? MAX_SIDE : height_reg;
    assign limit = 14'(w) * 14'(h);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_WIDTH)
                width_reg <= cfg_data;
            else
                height_reg <= cfg_data;
        end
    end

    assign diff = (clip_end_reg >= clip_start_reg) ? clip_end_reg - clip_start_reg : '0;
    assign div_dividend = !cmd.div_sel_b ? a_reg : (op_reg == OP_PASTE) ? diff : b_reg;

    rrcp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (w),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // rectangle setup
    logic [COL_W-1:0]  r0, r1, c0, c1;
    logic [CNT_W-1:0]  prod0, prod1;
    logic [ADDR_W-1:0] p0, p1;
    logic [SIDE_W-1:0] cp_cols, cp_rows;
    logic [SIDE_W-1:0] ps_cols, w_left, h_left, vc, vr;
    logic [CNT_W-1:0]  ps_rows;

    assign r0 = (qa_reg < qb_reg) ? qa_reg[COL_W-1:0] : qb_reg[COL_W-1:0];
    assign r1 = (qa_reg < qb_reg) ? qb_reg[COL_W-1:0] : qa_reg[COL_W-1:0];
    assign c0 = (ra_reg < rb_reg) ? ra_reg : rb_reg;
    assign c1 = (ra_reg < rb_reg) ? rb_reg : ra_reg;
    assign prod0 = CNT_W'(r0) * CNT_W'(w);
    assign prod1 = CNT_W'(r1) * CNT_W'(w);
    assign p0 = ADDR_W'(prod0 + CNT_W'(c0));
    assign p1 = ADDR_W'(prod1 + CNT_W'(c1));
    assign cp_cols = SIDE_W'(c1) - SIDE_W'(c0) + SIDE_W'(1);
    assign cp_rows = SIDE_W'(r1) - SIDE_W'(r0) + SIDE_W'(1);

    assign ps_cols = SIDE_W'(clip_span_reg) + SIDE_W'(1);
    assign ps_rows = CNT_W'(qb_reg) + CNT_W'(1);
    assign w_left  = w - SIDE_W'(ra_reg);
    assign h_left  = h - SIDE_W'(qa_reg[COL_W-1:0]);
    assign vc = (ps_cols < w_left) ? ps_cols : w_left;
    assign vr = (ps_rows < CNT_W'(h_left)) ? ps_rows[SIDE_W-1:0] : h_left;

    logic row_end;
    assign row_end = col_reg == ncols_reg - SIDE_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_start_reg <= '0;
            clip_end_reg   <= '0;
            clip_span_reg  <= '0;
        end
        else if (cmd.setup && op_reg != OP_PASTE)
        begin
            clip_start_reg <= p0;
            clip_end_reg   <= p1;
            clip_span_reg  <= c1 - c0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= op_t'(in_data[2:0]);
            a_reg   <= in_data[14:3];
            b_reg   <= in_data[26:15];
            val_reg <= in_data[58:27];
        end
        if (cmd.cap_a)
        begin
            qa_reg <= div_quo;
            ra_reg <= div_rem;
        end
        if (cmd.cap_b)
        begin
            qb_reg <= div_quo;
            rb_reg <= div_rem;
        end
        if (cmd.setup)
        begin
            row_reg <= '0;
            col_reg <= '0;
            if (op_reg == OP_PASTE)
            begin
                nrows_reg      <= vr;
                ncols_reg      <= vc;
                src_reg        <= '0;
                src_row_reg    <= '0;
                src_stride_reg <= ps_cols;
                dst_reg        <= a_reg;
                dst_row_reg    <= a_reg;
                dst_stride_reg <= w;
            end
            else
            begin
                nrows_reg      <= cp_rows;
                ncols_reg      <= cp_cols;
                src_reg        <= p0;
                src_row_reg    <= p0;
                src_stride_reg <= w;
                dst_reg        <= '0;
                dst_row_reg    <= '0;
                dst_stride_reg <= cp_cols;
            end
        end
        else if (cmd.walk_write)
        begin
            if (row_end)
            begin
                col_reg     <= '0;
                row_reg     <= row_reg + SIDE_W'(1);
                src_row_reg <= src_row_reg + ADDR_W'(src_stride_reg);
                src_reg     <= src_row_reg + ADDR_W'(src_stride_reg);
                dst_row_reg <= dst_row_reg + ADDR_W'(dst_stride_reg);
                dst_reg     <= dst_row_reg + ADDR_W'(dst_stride_reg);
            end
            else
            begin
                col_reg <= col_reg + SIDE_W'(1);
                src_reg <= src_reg + ADDR_W'(1);
                dst_reg <= dst_reg + ADDR_W'(1);
            end
        end
    end

    // result accumulation
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rd_reg    <= '0;
            err_reg   <= 1'b0;
            moved_reg <= '0;
        end
        else
        begin
            if (cmd.set_err)
                err_reg <= 1'b1;
            if (cmd.cap_rd)
                rd_reg <= pix_rd_reg;
            if (cmd.walk_write)
                moved_reg <= moved_reg + CNT_W'(1);
        end
        if (cmd.out_load)
        begin
            out_rd_reg  <= rd_reg;
            out_st_reg  <= err_reg;
            out_cnt_reg <= moved_reg;
        end
    end

    // pixel store: one write, one registered read per cycle
    logic              pix_we;
    logic [ADDR_W-1:0] pix_waddr;
    logic [PIX_W-1:0]  pix_wdata;

    always_comb
    begin
        pix_we    = 1'b0;
        pix_waddr = a_reg;
        pix_wdata = val_reg;
        if (cmd.pix_wr_single)
        begin
            pix_we = 1'b1;
        end
        else if (cmd.walk_write && op_reg == OP_PASTE)
        begin
            pix_we    = 1'b1;
            pix_waddr = dst_reg;
            pix_wdata = clip_rd_reg;
        end
        else if (cmd.walk_write && op_reg == OP_CUT)
        begin
            pix_we    = 1'b1;
            pix_waddr = src_reg;
            pix_wdata = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pix_we)
            pix_mem[pix_waddr] <= pix_wdata;
        if (cmd.pix_rd_single)
            pix_rd_reg <= pix_mem[a_reg];
        else if (cmd.walk_read)
            pix_rd_reg <= pix_mem[src_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.walk_write && op_reg != OP_PASTE)
            clip_mem[dst_reg] <= pix_rd_reg;
        if (cmd.walk_read)
            clip_rd_reg <= clip_mem[src_reg];
    end

    assign stat.op        = op_reg;
    assign stat.a_bad     = {2'b00, a_reg} >= limit;
    assign stat.b_bad     = {2'b00, b_reg} >= limit;
    assign stat.div_done  = div_done;
    assign stat.walk_last = row_end && (row_reg == nrows_reg - SIDE_W'(1));

    assign out_data = {2'b00, out_cnt_reg, out_st_reg, out_rd_reg};

endmodule

`default_nettype wire

// ----- design/rrcp_ctrl.sv -----
// ----------------------------------------------------------------------------
// rrcp_ctrl
// Controller: sequences each request and owns the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module rrcp_ctrl
    import rrcp_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  wire logic     out_ready,
    input  wire dp_stat_t stat,
    output ctrl_cmd_t     cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                unique case (stat.op)
                    OP_WRITE:
                    begin
                        if (stat.a_bad)
                            cmd.set_err = 1'b1;
                        else
                            cmd.pix_wr_single = 1'b1;
                        state_next = S_DONE;
                    end
                    OP_READ:
                    begin
                        if (stat.a_bad)
                        begin
                            cmd.set_err = 1'b1;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            cmd.pix_rd_single = 1'b1;
                            state_next        = S_RDATA;
                        end
                    end
                    OP_COPY, OP_CUT:
                    begin
                        if (stat.a_bad || stat.b_bad)
                        begin
                            cmd.set_err = 1'b1;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = S_DIV_A;
                        end
                    end
                    OP_PASTE:
                    begin
                        if (stat.a_bad)
                        begin
                            cmd.set_err = 1'b1;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            cmd.div_start = 1'b1;
                            state_next    = S_DIV_A;
                        end
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_RDATA:
            begin
                cmd.cap_rd = 1'b1;
                state_next = S_DONE;
            end
            S_DIV_A:
            begin
                if (stat.div_done)
                begin
                    cmd.cap_a     = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel_b = 1'b1;
                    state_next    = S_DIV_B;
                end
            end
            S_DIV_B:
            begin
                if (stat.div_done)
                begin
                    cmd.cap_b  = 1'b1;
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_READ;
            end
            S_READ:
            begin
                cmd.walk_read = 1'b1;
                state_next    = S_WRITE;
            end
            S_WRITE:
            begin
                cmd.walk_write = 1'b1;
                state_next     = stat.walk_last ? S_DONE : S_READ;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (slot_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- design/rect_region_copy_paste_engine.sv -----
// ----------------------------------------------------------------------------
// rect_region_copy_paste_engine
// Pixel store with rectangle copy, cut and paste through a clipboard store.
// ----------------------------------------------------------------------------
//  channel   direction  signals                          carries
//  s_axis    in         s_tvalid s_tready s_tdata[63:0]  one operation request
//  m_axis    out        m_tvalid m_tready m_tdata[47:0]  one result per request
//  cfg       in         cfg_we cfg_index cfg_data[6:0]   image width / height
//
//  One request at a time. Write pixel, read pixel, a bad index and an
//  unknown opcode need no division. Copy, cut and paste run two row/column
//  divisions, then a read-then-write walk over the N pixels moved, with a
//  read state and a write state for each pixel. A finished result waits in
//  the output register while the next request is taken. Reset clears
//  control and sets both sizes to 16; the stores need no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module rect_region_copy_paste_engine
    import rrcp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // opcode[2:0], first_index[14:3], second_index[26:15], pixel_value[58:27]
    input  wire logic [63:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // read_data[31:0], status[32], moved_count[45:33]
    output logic [47:0]      m_tdata,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [6:0]  cfg_data
);

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    rrcp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rrcp_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_data  (m_tdata)
    );

endmodule

`default_nettype wire

// ----- verif/rect_region_copy_paste_engine_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rect_region_copy_paste_engine_checker
// Watches the request, result and size-write ports of the engine. Keeps its
// own pixel store, clipboard and image size, works out each result, and
// compares it field by field against what comes out.
// ----------------------------------------------------------------------------
`default_nettype none

module rect_region_copy_paste_engine_checker
    import rrcp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [63:0] s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [47:0] m_tdata,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [6:0]  cfg_data,
    output int               errors,
    output int               pending
);

    // highest field first, so read_data lands in the low bits
    typedef struct packed {
        logic [12:0] moved_count;
        logic        status;
        logic [31:0] read_data;
    } blit_result_t;

    logic [31:0] pix_mem [PIXELS];
    logic [31:0] clip_mem [PIXELS];
    int unsigned clip_first;
    int unsigned clip_last;
    int unsigned clip_cols_m1;
    logic [6:0]  width_reg;
    logic [6:0]  height_reg;
    blit_result_t due_results [$];
    int unsigned result_idx;

    function automatic int unsigned clamp_side(logic [6:0] v);
        if (v < 7'd1)
            return 1;
        if (v > MAX_SIDE)
            return MAX_SIDE;
        return v;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH result %0d %s: got %h expected %h", result_idx, what, got, want);
        errors++;
    endtask

    // Apply one request to the local stores and return its result.
    task automatic run_blit(input logic [63:0] req, output blit_result_t res);
        op_t         op;
        int unsigned a, b, w, h, lim;
        int unsigned r0, r1, c0, c1, k, tr, tc, cols, rows, vr, vc, p;
        op  = op_t'(req[2:0]);
        a   = req[14:3];
        b   = req[26:15];
        w   = clamp_side(width_reg);
        h   = clamp_side(height_reg);
        lim = w * h;
        k   = 0;
        res = '0;
        if (lim > PIXELS)
            lim = PIXELS;
        case (op)
            OP_WRITE, OP_READ:
            begin
                if (a >= lim)
                    res.status = 1'b1;
                else if (op == OP_WRITE)
                    pix_mem[a % PIXELS] = req[58:27];
                else
                    res.read_data = pix_mem[a % PIXELS];
            end
            OP_COPY, OP_CUT:
            begin
                if (a >= lim || b >= lim)
                    res.status = 1'b1;
                else
                begin
                    r0 = (a / w < b / w) ? a / w : b / w;
                    r1 = (a / w < b / w) ? b / w : a / w;
                    c0 = (a % w < b % w) ? a % w : b % w;
                    c1 = (a % w < b % w) ? b % w : a % w;
                    for (int unsigned r = r0; r <= r1; r++)
                        for (int unsigned c = c0; c <= c1; c++)
                        begin
                            p = (r * w + c) % PIXELS;
                            clip_mem[k % PIXELS] = pix_mem[p];
                            if (op == OP_CUT)
                                pix_mem[p] = '0;
                            k++;
                        end
                    clip_first   = (r0 * w + c0) & 12'hFFF;
                    clip_last    = (r1 * w + c1) & 12'hFFF;
                    clip_cols_m1 = (c1 - c0) & 6'h3F;
                    res.moved_count = 13'(k);
                end
            end
            OP_PASTE:
            begin
                if (a >= lim)
                    res.status = 1'b1;
                else
                begin
                    tr   = a / w;
                    tc   = a % w;
                    cols = clip_cols_m1 + 1;
                    rows = ((clip_last >= clip_first) ? clip_last - clip_first : 0) / w + 1;
                    vc   = (cols > w - tc) ? w - tc : cols;
                    vr   = (rows > h - tr) ? h - tr : rows;
                    for (int unsigned r = 0; r < vr; r++)
                        for (int unsigned c = 0; c < vc; c++)
                            pix_mem[((tr + r) * w + tc + c) % PIXELS] =
                                clip_mem[(r * cols + c) % PIXELS];
                    res.moved_count = 13'(vr * vc);
                end
            end
            default:
            begin
                // unknown opcode: all-zero result, nothing changes
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        blit_result_t want, got;
        if (!rst_n)
        begin
            width_reg    <= WIDTH_RST;
            height_reg   <= HEIGHT_RST;
            clip_first   = 0;
            clip_last    = 0;
            clip_cols_m1 = 0;
            errors       = 0;
            result_idx   = 0;
            due_results.delete();
        end
        else
        begin
            // Pop first: a result never belongs to a request taken at the same edge.
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[45:0];
                if (due_results.size() == 0)
                begin
                    $display("MISMATCH result %0d arrived with nothing outstanding", result_idx);
                    errors++;
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got.read_data !== want.read_data)
                        report("read_data", got.read_data, want.read_data);
                    if (got.status !== want.status)
                        report("status", got.status, want.status);
                    if (got.moved_count !== want.moved_count)
                        report("moved_count", got.moved_count, want.moved_count);
                end
                result_idx++;
            end
            if (s_tvalid && s_tready)
            begin
                run_blit(s_tdata, want);
                due_results.push_back(want);
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_WIDTH)
                    width_reg <= cfg_data;
                else
                    height_reg <= cfg_data;
            end
        end
    end

    assign pending = due_results.size();

endmodule

`default_nettype wire

// ----- verif/rect_region_copy_paste_engine_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rect_region_copy_paste_engine_tb
// Drives pixel writes, reads, rectangle copy/cut/paste and size changes into
// the engine under random flow control; the checker predicts every result.
// ----------------------------------------------------------------------------
`default_nettype none

module rect_region_copy_paste_engine_tb;
    import rrcp_pkg::*;

    localparam int IDLE_LIMIT = 5000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;
    logic        cfg_we;
    logic        cfg_index;
    logic [6:0]  cfg_data;
    int          errors;
    int          pending;

    int          sent;
    int          got;
    int          idle_cycles;
    int          hold_asks;
    int          holds_done;
    bit          steady;

    // size as the block sees it, and what is safe to touch
    int unsigned img_w, img_h, img_lim;
    int unsigned pixels_ready;
    bit          clip_ready;
    int          n_region;
    int          n_sizes;

    rect_region_copy_paste_engine uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    rect_region_copy_paste_engine_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sent        <= 0;
            got         <= 0;
            idle_cycles <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                sent <= sent + 1;
            if (m_tvalid && m_tready)
                got <= got + 1;
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
                $display("rect_region_copy_paste_engine test failed");
                $finish;
            end
        end
    end

    // result side: random back-pressure, plus long holds on request
    initial
    begin
        int gap;
        m_tready = 1'b0;
        holds_done = 0;
        @(posedge rst_n);
        forever
        begin
            if (holds_done != hold_asks)
            begin
                m_tready <= 1'b0;
                repeat (200) @(posedge clk);
                holds_done++;
            end
            gap = pick_gap();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
        end
    end

    task automatic send_req(op_t op, int unsigned a, int unsigned b, logic [31:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, v, b[11:0], a[11:0], op};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (op == OP_COPY || op == OP_CUT || op == OP_PASTE)
            n_region++;
        if ((op == OP_COPY || op == OP_CUT) && a < img_lim && b < img_lim)
            clip_ready = 1'b1;
    endtask

    function automatic int unsigned any_pixel();
        return $urandom_range(0, img_lim - 1);
    endfunction

    // Change the size between requests once every result is back, then
    // fill any pixels not yet written and take a fresh clipboard so no
    // paste reads clipboard words laid out for another width.
    task automatic resize(logic [6:0] wv, logic [6:0] hv);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (got != sent)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WIDTH;
        cfg_data  <= wv;
        @(posedge clk);
        cfg_index <= CFG_HEIGHT;
        cfg_data  <= hv;
        @(posedge clk);
        cfg_we <= 1'b0;
        img_w   = (wv == 0) ? 1 : (wv > MAX_SIDE) ? MAX_SIDE : wv;
        img_h   = (hv == 0) ? 1 : (hv > MAX_SIDE) ? MAX_SIDE : hv;
        img_lim = img_w * img_h;
        clip_ready = 1'b0;
        n_sizes++;
        for (int unsigned i = pixels_ready; i < img_lim; i++)
            send_req(OP_WRITE, i, $urandom, $urandom);
        if (img_lim > pixels_ready)
            pixels_ready = img_lim;
        send_req(OP_COPY, any_pixel(), any_pixel(), $urandom);
    endtask

    task automatic random_reqs(int count);
        int r;
        int unsigned bad;
        repeat (count)
        begin
            r   = $urandom_range(0, 99);
            bad = $urandom_range(img_lim, 4095);
            if (r < 14)
                send_req(OP_WRITE, any_pixel(), $urandom, $urandom);
            else if (r < 28)
                send_req(OP_READ, any_pixel(), $urandom, $urandom);
            else if (r < 46)
                send_req(OP_COPY, any_pixel(), any_pixel(), $urandom);
            else if (r < 60)
                send_req(OP_CUT, any_pixel(), any_pixel(), $urandom);
            else if (r < 80)
                send_req(clip_ready ? OP_PASTE : OP_COPY, any_pixel(), any_pixel(), $urandom);
            else if (r < 86)
                send_req(op_t'($urandom_range(OP_WRITE, OP_PASTE)), bad, $urandom, $urandom);
            else if (r < 92)
                send_req(OP_COPY, any_pixel(), bad, $urandom);
            else
                send_req(op_t'($urandom_range(int'(OP_PASTE) + 1, 7)),
                         $urandom, $urandom, $urandom);
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_WIDTH;
        cfg_data  = '0;
        hold_asks = 0;
        steady    = 1'b0;
        pixels_ready = 0;
        n_region  = 0;
        n_sizes   = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, corner orders, clipping, bad indices
        resize(7'd4, 7'd4);
        send_req(OP_WRITE, 0, 0, 32'h0000_0000);
        send_req(OP_WRITE, 15, 4095, 32'hFFFF_FFFF);
        send_req(OP_READ, 0, 0, 0);
        send_req(OP_READ, 15, 0, 0);
        send_req(OP_COPY, 15, 0, 0);
        send_req(OP_PASTE, 0, 0, 0);
        send_req(OP_COPY, 3, 12, 0);
        send_req(OP_CUT, 9, 6, 0);
        send_req(OP_PASTE, 15, 0, 0);
        send_req(OP_PASTE, 3, 0, 0);
        send_req(OP_PASTE, 12, 0, 0);
        send_req(OP_WRITE, 4095, 0, 32'hFFFF_FFFF);
        send_req(OP_READ, 16, 0, 0);
        send_req(OP_COPY, 5, 4095, 0);
        send_req(OP_CUT, 4095, 5, 0);
        send_req(OP_PASTE, 16, 0, 0);
        send_req(op_t'(3'h7), 4095, 4095, 32'hFFFF_FFFF);
        send_req(op_t'(3'h5), 0, 0, 0);
        random_reqs(6);

        // hold results off while requests keep coming
        resize(7'd1, 7'd64);
        hold_asks = 1;
        random_reqs(8);

        resize(7'd64, 7'd1);
        steady = 1'b1;
        random_reqs(8);
        steady = 1'b0;

        resize(7'd0, 7'd127);
        random_reqs(6);
        resize(7'd127, 7'd0);
        random_reqs(6);
        resize(7'd8, 7'd5);
        random_reqs(6);
        resize(7'd3, 7'd7);
        random_reqs(6);
        resize(7'd64, 7'd1);
        random_reqs(6);

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (got != sent)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("covered %0d requests (%0d rectangle ops) over %0d image sizes",
                 sent, n_region, n_sizes);
        $display("%0d mismatches, %0d results still outstanding", errors, pending);
        if (errors == 0 && pending == 0)
            $display("rect_region_copy_paste_engine test passed");
        else
            $display("rect_region_copy_paste_engine test failed");
        $finish;
    end

endmodule

`default_nettype wire
